// ===== design/srs_pkg.sv =====
// Shared types and constants for the sequence reorder scheduler.
// Used by srs_ctrl, srs_datapath and sequence_reorder_scheduler_unit.
`default_nettype none
package srs_pkg;

   localparam int SEQ_W       = 64;
   localparam int TAG_W       = 16;
   localparam int PORT_W      = 2;
   localparam int CNT_W       = 7;
   localparam int IDX_W       = 6;
   localparam int STORE_DEPTH = 64;
   localparam int CREDIT_W    = 5;
   localparam int TICK_W      = 16;
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 32;

   localparam logic [CREDIT_W-1:0] CREDIT_RESET = 5'd10;
   localparam logic [TICK_W-1:0]   FIRST_RESET  = 16'd10000;
   localparam logic [TICK_W-1:0]   TMO_RESET    = 16'd1;

   typedef enum logic [1:0] {
      ACT_ARRIVE = 2'd0,
      ACT_PULL   = 2'd1,
      ACT_TICK   = 2'd2,
      ACT_NOP    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REG_CREDIT  = 2'd0,
      REG_FIRST   = 2'd1,
      REG_TIMEOUT = 2'd2,
      REG_NONE    = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [TAG_W-1:0]  tag;
      logic [PORT_W-1:0] port;
      logic [SEQ_W-1:0]  seq;
   } entry_type;

   typedef struct packed {
      logic capture;
      logic scan_issue;
      logic shift_start;
      logic shift_issue;
      logic finish;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       count_zero;
      logic       scan_last;
      logic       shift_more;
      logic       rd_busy;
      logic       release_ok;
      logic       out_free;
   } sts_type;

endpackage
`default_nettype wire

// ===== design/sequence_reorder_scheduler_unit.sv =====
// Top level of the sequence reorder scheduler.
// Depends on srs_pkg, srs_ctrl and srs_datapath.
//
// Usage:
//  - req_ channel carries one transaction: action (arrive, pull, tick, no-op),
//    port, seq_num and tag. Accepted when req_valid is high and req_stall low.
//  - rsp_ channel returns exactly one result per transaction, in order.
//  - APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds
//    credit_per_port at 0x0, first_timeout_ticks at 0x4, timeout_ticks at 0x8.
//    pready is tied high; write only while the block is idle.
// Sequencing:
//  - Arrive, tick and no-op: accept, dispatch, finish; the result register
//    loads at finish and the next transaction is taken back in idle.
//  - Pull: one read per entry held for the min scan through the single
//    read port of the entry memory, then one read per entry above the
//    released one to shift the list down, which keeps equal numbers in
//    arrival order.
//  - One transaction in flight at a time; req_stall is high while busy.
// Reset (synchronous, active high) empties the store, reloads credits and
// the first timeout; no clearing pass. A stalled result sits in the output
// register; the next transaction is still taken and waits at its finish
// step until the output register frees.
`default_nettype none
module sequence_reorder_scheduler_unit
   import srs_pkg::*;
#(
   parameter int NUM_PORTS  = 4,
   parameter int MAX_CREDIT = 16
)
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [1:0]         req_action,
   input  wire  [PORT_W-1:0]  req_port,
   input  wire  [SEQ_W-1:0]   req_seq_num,
   input  wire  [TAG_W-1:0]   req_tag,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic               rsp_released,
   output logic [TAG_W-1:0]   rsp_out_tag,
   output logic [PORT_W-1:0]  rsp_out_port,
   output logic [SEQ_W-1:0]   rsp_out_seq_num,
   output logic               rsp_accepted,
   output logic [CNT_W-1:0]   rsp_occupancy,
   output logic [SEQ_W-1:0]   rsp_last_released,
   input  wire                psel,
   input  wire                penable,
   input  wire                pwrite,
   input  wire  [ADDR_W-1:0]  paddr,
   input  wire  [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   cmd_type cmd;
   sts_type sts;

   srs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   srs_datapath #(
      .NUM_PORTS  (NUM_PORTS),
      .MAX_CREDIT (MAX_CREDIT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_action        (req_action),
      .req_port          (req_port),
      .req_seq_num       (req_seq_num),
      .req_tag           (req_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_released      (rsp_released),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_out_port      (rsp_out_port),
      .rsp_out_seq_num   (rsp_out_seq_num),
      .rsp_accepted      (rsp_accepted),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_last_released (rsp_last_released),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

endmodule
`default_nettype wire

// ===== design/srs_ctrl.sv =====
// Controller state machine of the sequence reorder scheduler.
// Depends on srs_pkg; drives commands into srs_datapath.
`default_nettype none
module srs_ctrl
   import srs_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.action == ACT_PULL && !sts.count_zero) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (sts.release_ok) begin
               cmd.shift_start = 1'b1;
               state_in        = ST_SHIFT;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_SHIFT: begin
            cmd.shift_issue = sts.shift_more;
            if (!sts.shift_more && !sts.rd_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== design/srs_datapath.sv =====
// Datapath: entry memory, min scan, shift-down removal, credits, timer, CSRs, result register.
// Depends on srs_pkg; commanded by srs_ctrl.
`default_nettype none
module srs_datapath
   import srs_pkg::*;
#(
   parameter int NUM_PORTS  = 4,
   parameter int MAX_CREDIT = 16
)
(
   input  wire                clock,
   input  wire                reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  wire  [1:0]         req_action,
   input  wire  [PORT_W-1:0]  req_port,
   input  wire  [SEQ_W-1:0]   req_seq_num,
   input  wire  [TAG_W-1:0]   req_tag,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic               rsp_released,
   output logic [TAG_W-1:0]   rsp_out_tag,
   output logic [PORT_W-1:0]  rsp_out_port,
   output logic [SEQ_W-1:0]   rsp_out_seq_num,
   output logic               rsp_accepted,
   output logic [CNT_W-1:0]   rsp_occupancy,
   output logic [SEQ_W-1:0]   rsp_last_released,
   input  wire                psel,
   input  wire                penable,
   input  wire                pwrite,
   input  wire  [ADDR_W-1:0]  paddr,
   input  wire  [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   localparam int CRED_W = $clog2(MAX_CREDIT + 1);
   localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_CREDIT);

   entry_type mem [STORE_DEPTH];

   // captured transaction
   action_type        act_ff;
   entry_type         in_ff;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  ptr_ff;
   logic              rd_vld_ff;
   logic              shifting_ff;
   logic [CNT_W-1:0]  rd_addr_ff;
   entry_type         rd_data_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   entry_type         best_ff;
   logic              rel_ff;

   logic [SEQ_W-1:0]  last_ff;
   logic              pending_ff;
   logic              first_ff;
   logic [TICK_W-1:0] tick_ff;
   logic [CREDIT_W-1:0] cfg_credit_ff;
   logic [TICK_W-1:0] cfg_first_ff;
   logic [TICK_W-1:0] cfg_tmo_ff;
   logic [CRED_W-1:0] credit_ff [NUM_PORTS];
   logic [CNT_W-1:0]  held_ff [NUM_PORTS];

   logic              rsp_valid_ff;
   logic              rsp_rel_ff;
   entry_type         rsp_ent_ff;
   logic              rsp_acc_ff;
   logic [CNT_W-1:0]  rsp_occ_ff;
   logic [SEQ_W-1:0]  rsp_last_ff;

   logic              csr_wr;
   reg_index_type     csr_idx;
   logic [CREDIT_W-1:0] new_credit;
   logic [CNT_W-1:0]  new_eff;
   logic [SEQ_W-1:0]  next_seq;
   logic              arr_ok;
   logic              port_in_range;
   logic              port_has_credit;
   logic              shift_wr;
   logic              arr_wr;
   logic              scan_take;
   logic [TICK_W-1:0] tmo_reload;
   logic [TICK_W-1:0] first_val;
   logic              out_free;

   assign pready   = 1'b1;
   assign csr_wr   = psel & penable & pwrite;
   assign csr_idx  = reg_index_type'(paddr[3:2]);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (csr_idx)
         REG_CREDIT:  prdata = DATA_W'(cfg_credit_ff);
         REG_FIRST:   prdata = DATA_W'(cfg_first_ff);
         REG_TIMEOUT: prdata = DATA_W'(cfg_tmo_ff);
         default:     prdata = '0;
      endcase
   end

   // effective credit: 0 acts as 1, clamp at MAX_CREDIT
   function automatic logic [CNT_W-1:0] clamp_credit(input logic [CREDIT_W-1:0] v);
      logic [CNT_W-1:0] w;
      w = CNT_W'(v);
      if (w == '0) begin
         return CNT_W'(1);
      end else if (w > MAX_C) begin
         return MAX_C;
      end else begin
         return w;
      end
   endfunction

   assign new_credit = pwdata[CREDIT_W-1:0];
   assign new_eff    = clamp_credit(new_credit);
   assign tmo_reload = (cfg_tmo_ff == '0) ? TICK_W'(1) : cfg_tmo_ff;
   assign first_val  = (pwdata[TICK_W-1:0] == '0) ? TICK_W'(1) : pwdata[TICK_W-1:0];
   assign next_seq   = last_ff + SEQ_W'(1);

   always_comb begin
      port_in_range   = (32'(in_ff.port) < NUM_PORTS);
      port_has_credit = 1'b0;
      for (int p = 0; p < NUM_PORTS; p++) begin
         if (32'(in_ff.port) == p && credit_ff[p] != '0) begin
            port_has_credit = 1'b1;
         end
      end
   end
   assign arr_ok = port_in_range && port_has_credit && (count_ff < CNT_W'(STORE_DEPTH));

   assign shift_wr  = rd_vld_ff && shifting_ff;
   assign arr_wr    = cmd.finish && act_ff == ACT_ARRIVE && arr_ok;
   assign scan_take = rd_vld_ff && !shifting_ff &&
                      (rd_addr_ff == '0 || rd_data_ff.seq < best_ff.seq);

   always_comb begin
      sts.action     = act_ff;
      sts.count_zero = (count_ff == '0);
      sts.scan_last  = (ptr_ff + CNT_W'(1) >= count_ff);
      sts.shift_more = (ptr_ff < count_ff);
      sts.rd_busy    = rd_vld_ff;
      sts.release_ok = pending_ff || best_ff.seq == '0 || best_ff.seq <= next_seq;
      sts.out_free   = out_free;
   end

   // entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (shift_wr) begin
         mem[IDX_W'(rd_addr_ff - CNT_W'(1))] <= rd_data_ff;
      end else if (arr_wr) begin
         mem[count_ff[IDX_W-1:0]] <= in_ff;
      end
      rd_data_ff <= mem[ptr_ff[IDX_W-1:0]];
      rd_addr_ff <= ptr_ff;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= action_type'(req_action);
         in_ff    <= '{tag: req_tag, port: req_port, seq: req_seq_num};
      end
      if (scan_take) begin
         best_ff     <= rd_data_ff;
         best_idx_ff <= rd_addr_ff[IDX_W-1:0];
      end
      if (cmd.finish) begin
         rsp_rel_ff <= (act_ff == ACT_PULL) && rel_ff;
         rsp_ent_ff <= ((act_ff == ACT_PULL) && rel_ff) ? best_ff : '0;
         rsp_acc_ff <= arr_wr;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ptr_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         shifting_ff   <= 1'b0;
         rel_ff        <= 1'b0;
         last_ff       <= '0;
         pending_ff    <= 1'b0;
         first_ff      <= 1'b1;
         tick_ff       <= FIRST_RESET;
         cfg_credit_ff <= CREDIT_RESET;
         cfg_first_ff  <= FIRST_RESET;
         cfg_tmo_ff    <= TMO_RESET;
         rsp_valid_ff  <= 1'b0;
         rsp_occ_ff    <= '0;
         rsp_last_ff   <= '0;
         for (int p = 0; p < NUM_PORTS; p++) begin
            credit_ff[p] <= CRED_W'(clamp_credit(CREDIT_RESET));
            held_ff[p]   <= '0;
         end
      end else begin
         rd_vld_ff <= cmd.scan_issue || cmd.shift_issue;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_wr) begin
            case (csr_idx)
               REG_CREDIT: begin
                  cfg_credit_ff <= new_credit;
                  for (int p = 0; p < NUM_PORTS; p++) begin
                     credit_ff[p] <= (held_ff[p] >= new_eff) ? '0 :
                                     CRED_W'(new_eff - held_ff[p]);
                  end
               end
               REG_FIRST: begin
                  cfg_first_ff <= pwdata[TICK_W-1:0];
                  if (first_ff) begin
                     tick_ff <= first_val;
                  end
               end
               REG_TIMEOUT: begin
                  cfg_tmo_ff <= pwdata[TICK_W-1:0];
               end
               default: begin
               end
            endcase
         end

         if (cmd.capture) begin
            ptr_ff      <= '0;
            shifting_ff <= 1'b0;
            rel_ff      <= 1'b0;
         end
         if (cmd.scan_issue || cmd.shift_issue) begin
            ptr_ff <= ptr_ff + CNT_W'(1);
         end
         if (cmd.shift_start) begin
            ptr_ff      <= CNT_W'(best_idx_ff) + CNT_W'(1);
            shifting_ff <= 1'b1;
            rel_ff      <= 1'b1;
         end

         if (cmd.finish) begin
            rsp_occ_ff   <= count_ff;
            rsp_last_ff  <= last_ff;
            case (act_ff)
               ACT_ARRIVE: begin
                  if (arr_ok) begin
                     count_ff   <= count_ff + CNT_W'(1);
                     rsp_occ_ff <= count_ff + CNT_W'(1);
                     for (int p = 0; p < NUM_PORTS; p++) begin
                        if (32'(in_ff.port) == p) begin
                           credit_ff[p] <= credit_ff[p] - CRED_W'(1);
                           held_ff[p]   <= held_ff[p] + CNT_W'(1);
                        end
                     end
                  end
               end
               ACT_PULL: begin
                  if (rel_ff) begin
                     if (pending_ff || best_ff.seq == '0 || best_ff.seq == next_seq) begin
                        last_ff     <= best_ff.seq;
                        rsp_last_ff <= best_ff.seq;
                     end
                     pending_ff <= 1'b0;
                     first_ff   <= 1'b0;
                     tick_ff    <= tmo_reload;
                     count_ff   <= count_ff - CNT_W'(1);
                     rsp_occ_ff <= count_ff - CNT_W'(1);
                     for (int p = 0; p < NUM_PORTS; p++) begin
                        if (32'(best_ff.port) == p) begin
                           if (CNT_W'(credit_ff[p]) < MAX_C) begin
                              credit_ff[p] <= credit_ff[p] + CRED_W'(1);
                           end
                           held_ff[p] <= held_ff[p] - CNT_W'(1);
                        end
                     end
                  end
               end
               ACT_TICK: begin
                  if (tick_ff > TICK_W'(1)) begin
                     tick_ff <= tick_ff - TICK_W'(1);
                  end else begin
                     pending_ff <= 1'b1;
                     first_ff   <= 1'b0;
                     tick_ff    <= tmo_reload;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_released      = rsp_rel_ff;
   assign rsp_out_tag       = rsp_ent_ff.tag;
   assign rsp_out_port      = rsp_ent_ff.port;
   assign rsp_out_seq_num   = rsp_ent_ff.seq;
   assign rsp_accepted      = rsp_acc_ff;
   assign rsp_occupancy     = rsp_occ_ff;
   assign rsp_last_released = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STORE_DEPTH))
      else $error("entry count above store depth");

   a_arrive_grows: assert property (@(posedge clock) disable iff (reset)
      arr_wr |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("stored arrival did not grow the count");

   a_no_shift_write_on_arrive: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rd_vld_ff)
      else $error("memory read in flight at finish");

   a_rel_xor_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_rel_ff && rsp_acc_ff))
      else $error("result both released and accepted");

endmodule
`default_nettype wire

// ===== sim/sequence_reorder_scheduler_unit_test.sv =====
// Self-checking testbench for sequence_reorder_scheduler_unit: a directed table,
// then randomized phases under several register settings. Predicts each result.
// Depends on srs_pkg and the design sources only.
`default_nettype none
module sequence_reorder_scheduler_unit_test
   import srs_pkg::*;
;

   localparam int NPORTS      = 4;
   localparam int CREDIT_MAX  = 16;
   localparam int IDLE_LIMIT  = 5000;   // longest pull plus long receiver hold-off, with margin
   localparam int HOLD_CYCLES = 400;
   localparam int HOLD_AT     = 300;    // results seen before the long hold-off starts

   typedef struct packed {
      logic              released;
      logic [TAG_W-1:0]  tag;
      logic [PORT_W-1:0] port;
      logic [SEQ_W-1:0]  seq;
      logic              accepted;
      logic [CNT_W-1:0]  occupancy;
      logic [SEQ_W-1:0]  last;
   } result_type;

   typedef struct packed {
      action_type        action;
      logic [PORT_W-1:0] port;
      logic [SEQ_W-1:0]  seq;
      logic [TAG_W-1:0]  tag;
      logic              typed;     // expectation written in the row
      result_type        want;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_action = ACT_NOP;
   logic [PORT_W-1:0]  req_port = '0;
   logic [SEQ_W-1:0]   req_seq_num = '0;
   logic [TAG_W-1:0]   req_tag = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_released;
   logic [TAG_W-1:0]   rsp_out_tag;
   logic [PORT_W-1:0]  rsp_out_port;
   logic [SEQ_W-1:0]   rsp_out_seq_num;
   logic               rsp_accepted;
   logic [CNT_W-1:0]   rsp_occupancy;
   logic [SEQ_W-1:0]   rsp_last_released;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [ADDR_W-1:0]  paddr = '0;
   logic [DATA_W-1:0]  pwdata = '0;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   sequence_reorder_scheduler_unit u_dut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Reorder predictor: own copy of the store, credits and timer.
   // The store is kept in arrival order, so the first minimum found is
   // the oldest among equal numbers.
   // ---------------------------------------------------------------
   logic [TAG_W-1:0]  slot_tag  [STORE_DEPTH];
   logic [PORT_W-1:0] slot_port [STORE_DEPTH];
   logic [SEQ_W-1:0]  slot_seq  [STORE_DEPTH];
   int                held_count;
   int                credit_left [NPORTS];
   logic [SEQ_W-1:0]  last_in_order;
   logic              timeout_armed;
   int                ticks_left;
   logic              before_first_timeout;
   logic [CREDIT_W-1:0] cfg_credit;
   logic [TICK_W-1:0]   cfg_first;
   logic [TICK_W-1:0]   cfg_timeout;

   result_type pending_results[$];
   int         mismatches = 0;
   int         results_seen = 0;
   bit         gaps_on = 1'b1;

   function automatic int nonzero_ticks(logic [TICK_W-1:0] v);
      return (v == 0) ? 1 : int'(v);
   endfunction

   // credit minus entries held per port, floored at zero; 0 acts as 1, large clamps
   function void refill_credits();
      int limit;
      int held;
      limit = (cfg_credit == 0) ? 1 : (cfg_credit > CREDIT_MAX) ? CREDIT_MAX : int'(cfg_credit);
      for (int p = 0; p < NPORTS; p++) begin
         held = 0;
         for (int i = 0; i < held_count; i++)
            if (slot_port[i] == p) held++;
         credit_left[p] = (held >= limit) ? 0 : limit - held;
      end
   endfunction

   function void reset_predictor();
      cfg_credit = CREDIT_RESET;
      cfg_first = FIRST_RESET;
      cfg_timeout = TMO_RESET;
      held_count = 0;
      last_in_order = '0;
      timeout_armed = 1'b0;
      before_first_timeout = 1'b1;
      ticks_left = nonzero_ticks(cfg_first);
      refill_credits();
   endfunction

   function void write_setting(reg_index_type idx, logic [DATA_W-1:0] value);
      case (idx)
         REG_CREDIT: begin
            cfg_credit = value[CREDIT_W-1:0];
            refill_credits();
         end
         REG_FIRST: begin
            cfg_first = value[TICK_W-1:0];
            if (before_first_timeout) ticks_left = nonzero_ticks(cfg_first);
         end
         REG_TIMEOUT: cfg_timeout = value[TICK_W-1:0];
         default: ;
      endcase
   endfunction

   function result_type predict_reorder(action_type act, logic [PORT_W-1:0] port,
                                        logic [SEQ_W-1:0] seq, logic [TAG_W-1:0] tag);
      result_type r;
      int best;
      logic [SEQ_W-1:0] s;
      logic [SEQ_W-1:0] next_seq;
      r = '0;
      case (act)
         ACT_ARRIVE: begin
            if (port < NPORTS && credit_left[port] > 0 && held_count < STORE_DEPTH) begin
               slot_tag[held_count] = tag;
               slot_port[held_count] = port;
               slot_seq[held_count] = seq;
               held_count++;
               credit_left[port]--;
               r.accepted = 1'b1;
            end
         end
         ACT_PULL: begin
            if (held_count > 0) begin
               best = 0;
               for (int i = 1; i < held_count; i++)
                  if (slot_seq[i] < slot_seq[best]) best = i;
               s = slot_seq[best];
               next_seq = last_in_order + 1;
               // held back when above last+1, nonzero and no timeout pending
               if (timeout_armed || s == 0 || s <= next_seq) begin
                  if (timeout_armed || s == 0 || s == next_seq) last_in_order = s;
                  timeout_armed = 1'b0;
                  before_first_timeout = 1'b0;
                  ticks_left = nonzero_ticks(cfg_timeout);
                  if (credit_left[slot_port[best]] < CREDIT_MAX) credit_left[slot_port[best]]++;
                  r.released = 1'b1;
                  r.tag = slot_tag[best];
                  r.port = slot_port[best];
                  r.seq = s;
                  for (int i = best; i + 1 < held_count; i++) begin
                     slot_tag[i] = slot_tag[i+1];
                     slot_port[i] = slot_port[i+1];
                     slot_seq[i] = slot_seq[i+1];
                  end
                  held_count--;
               end
            end
         end
         ACT_TICK: begin
            if (ticks_left > 1) ticks_left--;
            else begin
               timeout_armed = 1'b1;
               before_first_timeout = 1'b0;
               ticks_left = nonzero_ticks(cfg_timeout);
            end
         end
         default: ;
      endcase
      r.occupancy = held_count[CNT_W-1:0];
      r.last = last_in_order;
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Sender: one transaction per call, random gap before it when gaps are on.
   // Valid stays high on return; the next call drives its own transaction or the caller lowers it.
   // ---------------------------------------------------------------
   task automatic send_transaction(action_type act, logic [PORT_W-1:0] port,
                                   logic [SEQ_W-1:0] seq, logic [TAG_W-1:0] tag,
                                   logic typed, result_type want);
      int gap;
      result_type r;
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_port <= port;
      req_seq_num <= seq;
      req_tag <= tag;
      do @(posedge clock); while (req_stall);
      r = predict_reorder(act, port, seq, tag);
      pending_results.push_back(typed ? want : r);
   endtask

   // APB write: setup phase, then access phase; register written at its end
   task automatic csr_write(reg_index_type idx, logic [DATA_W-1:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= ADDR_W'(4 * int'(idx));
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      write_setting(idx, value);
   endtask

   // let every outstanding transaction drain before touching registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // Receiver and checker. After each result a random wait is drawn when
   // gaps are on; once, a long hold-off backs the block up into its input.
   // ---------------------------------------------------------------
   int rsp_wait = 0;
   int long_hold = 0;
   bit long_hold_done = 1'b0;
   int idle_cycles = 0;

   always @(posedge clock) begin
      result_type want;
      int w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               $error("result with no transaction outstanding");
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_released !== want.released) begin
                  $error("released: expected %0d got %0d", want.released, rsp_released);
                  mismatches++;
               end
               if (rsp_out_tag !== want.tag) begin
                  $error("out_tag: expected %0h got %0h", want.tag, rsp_out_tag);
                  mismatches++;
               end
               if (rsp_out_port !== want.port) begin
                  $error("out_port: expected %0d got %0d", want.port, rsp_out_port);
                  mismatches++;
               end
               if (rsp_out_seq_num !== want.seq) begin
                  $error("out_seq_num: expected %0h got %0h", want.seq, rsp_out_seq_num);
                  mismatches++;
               end
               if (rsp_accepted !== want.accepted) begin
                  $error("accepted: expected %0d got %0d", want.accepted, rsp_accepted);
                  mismatches++;
               end
               if (rsp_occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d got %0d", want.occupancy, rsp_occupancy);
                  mismatches++;
               end
               if (rsp_last_released !== want.last) begin
                  $error("last_released: expected %0h got %0h", want.last, rsp_last_released);
                  mismatches++;
               end
            end
            if (!long_hold_done && results_seen >= HOLD_AT) begin
               long_hold_done = 1'b1;
               long_hold = HOLD_CYCLES;
            end
            w = gaps_on ? $urandom_range(0, 6) : 0;
            rsp_wait = (long_hold > 0) ? 0 : w;
         end
         if (long_hold > 0) begin
            long_hold--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: too long without any transaction moving
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else if (!reset && !psel) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Directed table, run with reset register values. Typed rows are
   // the ones readable at a glance: empty store, extremes, zero number.
   // ---------------------------------------------------------------
   localparam logic [SEQ_W-1:0] SEQ_MAX = '1;
   localparam int NROWS = 16;
   row_type directed [NROWS] = '{
      // pull on an empty store releases nothing
      '{ACT_PULL,   2'd0, 64'd0,   16'h0000, 1'b1, '{1'b0, 16'h0, 2'd0, 64'd0, 1'b0, 7'd0, 64'd0}},
      '{ACT_TICK,   2'd0, 64'd0,   16'h0000, 1'b1, '{1'b0, 16'h0, 2'd0, 64'd0, 1'b0, 7'd0, 64'd0}},
      // no-op action changes nothing
      '{ACT_NOP,    2'd3, SEQ_MAX, 16'hFFFF, 1'b1, '{1'b0, 16'h0, 2'd0, 64'd0, 1'b0, 7'd0, 64'd0}},
      '{ACT_ARRIVE, 2'd3, 64'd0,   16'hFFFF, 1'b1, '{1'b0, 16'h0, 2'd0, 64'd0, 1'b1, 7'd1, 64'd0}},
      '{ACT_ARRIVE, 2'd0, SEQ_MAX, 16'h0000, 1'b1, '{1'b0, 16'h0, 2'd0, 64'd0, 1'b1, 7'd2, 64'd0}},
      // number zero always leaves
      '{ACT_PULL,   2'd0, 64'd0,   16'h0000, 1'b1,
        '{1'b1, 16'hFFFF, 2'd3, 64'd0, 1'b0, 7'd1, 64'd0}},
      // all-ones is far above last+1: held back
      '{ACT_PULL,   2'd0, 64'd0,   16'h0000, 1'b1, '{1'b0, 16'h0, 2'd0, 64'd0, 1'b0, 7'd1, 64'd0}},
      '{ACT_ARRIVE, 2'd1, 64'd1,   16'h1234, 1'b0, '0},
      // equal number, must leave after the one above
      '{ACT_ARRIVE, 2'd2, 64'd1,   16'h4321, 1'b0, '0},
      '{ACT_PULL,   2'd0, 64'd0,   16'h0000, 1'b0, '0},
      // stale number: released, last stays
      '{ACT_PULL,   2'd0, 64'd0,   16'h0000, 1'b0, '0},
      '{ACT_ARRIVE, 2'd1, 64'd5,   16'hA5A5, 1'b0, '0},
      '{ACT_PULL,   2'd0, 64'd0,   16'h0000, 1'b0, '0},
      // timer restarted at one tick by the release: this tick times out
      '{ACT_TICK,   2'd0, 64'd0,   16'h0000, 1'b0, '0},
      '{ACT_PULL,   2'd0, 64'd0,   16'h0000, 1'b0, '0},
      '{ACT_PULL,   2'd0, 64'd0,   16'h0000, 1'b0, '0}
   };

   // random phase: mostly numbers near last+1 so pulls get through
   task automatic run_random(int items, int pull_pct, int tick_pct);
      int roll;
      int kind;
      action_type act;
      logic [SEQ_W-1:0] seq;
      for (int n = 0; n < items; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < pull_pct) act = ACT_PULL;
         else if (roll < pull_pct + tick_pct) act = ACT_TICK;
         else if (roll < pull_pct + tick_pct + 3) act = ACT_NOP;
         else act = ACT_ARRIVE;
         kind = $urandom_range(0, 99);
         if (kind < 80) seq = last_in_order + 64'($urandom_range(0, 6));
         else if (kind < 92) seq = {$urandom, $urandom};
         else if (kind < 96) seq = '0;
         else seq = SEQ_MAX;
         send_transaction(act, PORT_W'($urandom_range(0, 3)), seq, TAG_W'($urandom),
                          1'b0, '0);
      end
   endtask

   initial begin
      reset_predictor();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NROWS; i++)
         send_transaction(directed[i].action, directed[i].port, directed[i].seq,
                          directed[i].tag, directed[i].typed, directed[i].want);

      // credit 16 fills the 64-entry store; short timers
      wait_idle();
      csr_write(REG_CREDIT, 32'd16);
      csr_write(REG_FIRST, 32'd3);
      csr_write(REG_TIMEOUT, 32'd2);
      run_random(450, 15, 10);

      // one credit per port, longest timers, no idling
      wait_idle();
      gaps_on = 1'b0;
      csr_write(REG_CREDIT, 32'd1);
      csr_write(REG_FIRST, 32'd65535);
      csr_write(REG_TIMEOUT, 32'd65535);
      run_random(300, 40, 5);

      // zero values act as one
      wait_idle();
      gaps_on = 1'b1;
      csr_write(REG_CREDIT, 32'd0);
      csr_write(REG_FIRST, 32'd0);
      csr_write(REG_TIMEOUT, 32'd0);
      run_random(300, 40, 20);

      // credit above the maximum clamps
      wait_idle();
      csr_write(REG_CREDIT, 32'd31);
      csr_write(REG_FIRST, 32'd5);
      csr_write(REG_TIMEOUT, 32'd1);
      run_random(450, 30, 15);

      // credit lowered below what ports may hold
      wait_idle();
      csr_write(REG_CREDIT, 32'd4);
      csr_write(REG_FIRST, 32'd1);
      csr_write(REG_TIMEOUT, 32'd7);
      run_random(430, 40, 20);

      wait_idle();
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
`default_nettype wire
